// ----- rtl/ibo_pkg.sv -----
// Package for the inode byte offset unit: register indexes, widths and constants.
// No dependencies; used by the top level and the testbench.
`default_nettype none
package ibo_pkg;

  localparam int unsigned SystemInodes  = 11;
  localparam int unsigned BaseBlockSize = 1024;

  localparam int unsigned NumW   = 32;
  localparam int unsigned IpgW   = 17;
  localparam int unsigned BpgW   = 17;
  localparam int unsigned LbsW   = 3;
  localparam int unsigned IszW   = 11;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInodesPerGroup = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlocksPerGroup = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLogBlockSize   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInodeSize      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInodeTableBlk  = 3'd4;

  // True for 0, 1, or any power of 3, 5 or 7 that fits in 32 bits
  function automatic logic is_backup(input logic [NumW-1:0] g);
    logic [63:0] p3;
    logic [63:0] p5;
    logic [63:0] p7;
    logic        hit;
    hit = (g == '0);
    p3 = 64'd1;
    p5 = 64'd1;
    p7 = 64'd1;
    for (int i = 0; i < 21; i++) begin
      if ({32'd0, g} == p3) hit = 1'b1;
      p3 = p3 * 64'd3;
    end
    for (int i = 0; i < 14; i++) begin
      if ({32'd0, g} == p5) hit = 1'b1;
      p5 = p5 * 64'd5;
    end
    for (int i = 0; i < 12; i++) begin
      if ({32'd0, g} == p7) hit = 1'b1;
      p7 = p7 * 64'd7;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/inode_byte_offset_calc_unit.sv -----
// Throughput one item per cycle while the output is not stalled.
// The 32/17 restoring divider takes one quotient bit per stage (32 stages), followed
// by four stages of multiply and add.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (async, active low) clears all valid bits and loads the configuration defaults.
// Top level of the inode byte offset unit; depends on ibo_pkg.
`default_nettype none
module inode_byte_offset_calc_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] inode_number_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      byte_offset_o,
  output logic [31:0]      group_number_o,
  output logic             backup_group_o
);

  localparam int unsigned NW = ibo_pkg::NumW;
  localparam int unsigned DW = ibo_pkg::IpgW;

  // configuration registers
  logic [ibo_pkg::IpgW-1:0] ipg_q;
  logic [ibo_pkg::BpgW-1:0] bpg_q;
  logic [ibo_pkg::LbsW-1:0] lbs_q;
  logic [ibo_pkg::IszW-1:0] isz_q;
  logic [NW-1:0]            itb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipg_q <= 17'd2048;
      bpg_q <= 17'd8192;
      lbs_q <= '0;
      isz_q <= 11'd128;
      itb_q <= 32'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ibo_pkg::RegInodesPerGroup: ipg_q <= cfg_wdata_i[ibo_pkg::IpgW-1:0];
        ibo_pkg::RegBlocksPerGroup: bpg_q <= cfg_wdata_i[ibo_pkg::BpgW-1:0];
        ibo_pkg::RegLogBlockSize:   lbs_q <= cfg_wdata_i[ibo_pkg::LbsW-1:0];
        ibo_pkg::RegInodeSize:      isz_q <= cfg_wdata_i[ibo_pkg::IszW-1:0];
        ibo_pkg::RegInodeTableBlk:  itb_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is held by the sink
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // block size; the user must keep it stable while items are in flight, the block does not enforce it
  logic [NW-1:0] bsize;
  assign bsize = NW'(ibo_pkg::BaseBlockSize) << lbs_q;

  // divider stages: index k holds state after k quotient bits
  logic          dv_q  [1:NW];
  logic [DW-1:0] rem_q [1:NW];
  logic [NW-1:0] quo_q [1:NW];
  logic [NW-1:0] num_q [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic          s_v;
    logic [DW-1:0] s_rem;
    logic [NW-1:0] s_quo;
    logic [NW-1:0] s_num;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] quo_d;
    // first stage takes the incoming item, the others the previous stage
    if (k == 0) begin : g_head
      assign s_v   = in_valid_i;
      assign s_rem = '0;
      assign s_quo = '0;
      assign s_num = inode_number_i;
    end else begin : g_body
      assign s_v   = dv_q[k];
      assign s_rem = rem_q[k];
      assign s_quo = quo_q[k];
      assign s_num = num_q[k];
    end
    always_comb begin
      trial = {s_rem, s_num[NW-1-k]};
      ge    = (trial >= {1'b0, ipg_q});
      rem_d = ge ? DW'(trial - {1'b0, ipg_q}) : trial[DW-1:0];
      quo_d = s_quo;
      quo_d[NW-1-k] = ge;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= s_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= quo_d;
        num_q[k+1] <= s_num;
      end
    end
  end

  // divide by zero: group all ones, index is the whole number
  logic [NW-1:0] grp;
  logic [NW-1:0] idx;
  assign grp = (ipg_q == '0) ? '1 : quo_q[NW];
  assign idx = (ipg_q == '0) ? num_q[NW] : NW'(rem_q[NW]);

  // M1: backup test, group * blocks_per_group, offset within the table
  logic          m1_v_q;
  logic [NW-1:0] m1_grp_q, m1_p1_q, m1_it_q;
  logic          m1_bk_q;
  logic          rsv;
  logic [NW-1:0] it_prod;
  assign rsv     = (grp == '0) && (idx < NW'(ibo_pkg::SystemInodes));
  assign it_prod = NW'((rsv ? idx : idx - NW'(1)) * {21'd0, isz_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_v_q <= 1'b0;
    else if (adv) m1_v_q <= dv_q[NW];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_grp_q <= grp;
      m1_bk_q  <= ibo_pkg::is_backup(grp);
      m1_p1_q  <= NW'(grp * {15'd0, bpg_q});
      m1_it_q  <= rsv ? (it_prod >> 1) : it_prod;
    end
  end

  // M2: group base in bytes
  logic          m2_v_q, m2_bk_q;
  logic [NW-1:0] m2_grp_q, m2_p3_q, m2_it_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_v_q <= 1'b0;
    else if (adv) m2_v_q <= m1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_grp_q <= m1_grp_q;
      m2_bk_q  <= m1_bk_q;
      m2_p3_q  <= NW'(m1_p1_q * bsize);
      m2_it_q  <= m1_it_q;
    end
  end

  // M3: table start in bytes, partial sum
  logic          m3_v_q, m3_bk_q;
  logic [NW-1:0] m3_grp_q, m3_p2_q, m3_s1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3_v_q <= 1'b0;
    else if (adv) m3_v_q <= m2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_grp_q <= m2_grp_q;
      m3_bk_q  <= m2_bk_q;
      m3_p2_q  <= NW'((m2_bk_q ? itb_q : NW'(2)) * bsize);
      m3_s1_q  <= m2_p3_q + m2_it_q;
    end
  end

  // M4: output register
  logic          out_v_q, out_bk_q;
  logic [NW-1:0] out_grp_q, out_off_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= m3_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_grp_q <= m3_grp_q;
      out_bk_q  <= m3_bk_q;
      out_off_q <= m3_s1_q + m3_p2_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign byte_offset_o  = out_off_q;
  assign group_number_o = out_grp_q;
  assign backup_group_o = out_bk_q;

endmodule
`default_nettype wire

// ----- rtl/ibo_checker.sv -----
// Port-level checker for the inode byte offset unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module ibo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] byte_offset_o,
  input wire logic [31:0] group_number_o,
  input wire logic        backup_group_o
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(byte_offset_o)
      && $stable(group_number_o) && $stable(backup_group_o)))
    else $error("result changed while stalled");

  // input stall only comes from a blocked output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // groups 0 and 1 are always backup groups
  a_bk01: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (group_number_o == 32'd0 || group_number_o == 32'd1))
      |-> backup_group_o)
    else $error("group 0 or 1 not flagged as backup");

  // group 2 is never a backup group
  a_bk2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && group_number_o == 32'd2) |-> !backup_group_o)
    else $error("group 2 flagged as backup");

endmodule

bind inode_byte_offset_calc_unit ibo_checker u_ibo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .byte_offset_o  (byte_offset_o),
  .group_number_o (group_number_o),
  .backup_group_o (backup_group_o)
);
`default_nettype wire

// ----- tb/sv/inode_byte_offset_calc_unit_tb.sv -----
// Testbench for inode_byte_offset_calc_unit: directed table and zero inodes per group items, then random items,
// checked against typed rows or an in-bench location predictor. Depends on ibo_pkg and the RTL.
`default_nettype none
module inode_byte_offset_calc_unit_tb;

  localparam int unsigned NumRandom = 850;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] group;
    logic        backup;
  } loc_t;

  typedef struct {
    logic [31:0] num;
    logic        typed;
    loc_t        want;
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] inode_number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] byte_offset_o;
  logic [31:0] group_number_o;
  logic        backup_group_o;

  inode_byte_offset_calc_unit uut (.*);

  // Shadow of the configuration registers
  logic [16:0] ipg_q;
  logic [16:0] bpg_q;
  logic [2:0]  lbs_q;
  logic [10:0] isz_q;
  logic [31:0] itb_q;

  loc_t        loc_q[$];
  int          errors;
  logic        hold_off;
  logic        quiet;

  // Power test by repeated division
  function automatic logic pow_of(input logic [31:0] v, input logic [31:0] b);
    if (v == 0) return 1'b0;
    while (v != 1) begin
      if (v % b != 0) return 1'b0;
      v = v / b;
    end
    return 1'b1;
  endfunction

  function automatic loc_t locate(input logic [31:0] num);
    logic [31:0] grp, idx, bsz, blk, tbl;
    loc_t r;
    if (ipg_q == 0) begin
      grp = '1;
      idx = num;
    end else begin
      grp = num / {15'd0, ipg_q};
      idx = num % {15'd0, ipg_q};
    end
    bsz = 32'(ibo_pkg::BaseBlockSize) << lbs_q;
    r.backup = (grp == 0) || pow_of(grp, 3) || pow_of(grp, 5) || pow_of(grp, 7);
    blk = r.backup ? itb_q : 32'd2;
    if (grp == 0 && idx < ibo_pkg::SystemInodes) tbl = (idx * {21'd0, isz_q}) / 2;
    else tbl = (idx - 32'd1) * {21'd0, isz_q};
    r.offset = grp * {15'd0, bpg_q} * bsz + blk * bsz + tbl;
    r.group = grp;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result checker and stall generator
  always @(posedge clk_i) begin
    loc_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (loc_q.size() == 0) begin
        $display("%0t: unexpected item off=%h grp=%h bk=%b", $time,
                 byte_offset_o, group_number_o, backup_group_o);
        errors++;
      end else begin
        w = loc_q.pop_front();
        if (w.offset !== byte_offset_o)
          $display("%0t: offset exp %h got %h", $time, w.offset, byte_offset_o);
        if (w.group !== group_number_o)
          $display("%0t: group exp %h got %h", $time, w.group, group_number_o);
        if (w.backup !== backup_group_o)
          $display("%0t: backup exp %b got %b", $time, w.backup, backup_group_o);
        if (w.offset !== byte_offset_o || w.group !== group_number_o ||
            w.backup !== backup_group_o) errors++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 32);
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ibo_pkg::RegInodesPerGroup: ipg_q = val[16:0];
      ibo_pkg::RegBlocksPerGroup: bpg_q = val[16:0];
      ibo_pkg::RegLogBlockSize:   lbs_q = val[2:0];
      ibo_pkg::RegInodeSize:      isz_q = val[10:0];
      ibo_pkg::RegInodeTableBlk:  itb_q = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [31:0] ipg, bpg, lbs, isz, itb);
    cfg_write(ibo_pkg::RegInodesPerGroup, ipg);
    cfg_write(ibo_pkg::RegBlocksPerGroup, bpg);
    cfg_write(ibo_pkg::RegLogBlockSize, lbs);
    cfg_write(ibo_pkg::RegInodeSize, isz);
    cfg_write(ibo_pkg::RegInodeTableBlk, itb);
  endtask

  // Offer one item; enqueue expectation at the accepting edge.
  // Valid stays high after the accept; the next item, a gap or drain() sets it.
  task automatic send_item(input logic [31:0] num, input logic gaps, input loc_t want,
                           input logic typed);
    if (gaps) while ($urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    inode_number_i <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    loc_q.push_back(typed ? want : locate(num));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (loc_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Pick random or near-maximum numbers, or ones on backup groups, group edges and reserved inodes
  function automatic logic [31:0] pick_num();
    logic [31:0] g, ipg;
    int k;
    ipg = (ipg_q == 0) ? 32'd1 : {15'd0, ipg_q};
    k = $urandom_range(5);
    case (k)
      0: return $urandom();
      1: return $urandom_range(20);
      2: begin
        g = 3 ** $urandom_range(6);
        return g * ipg + $urandom_range(2);
      end
      3: begin
        g = $urandom_range(400);
        return g * ipg + ($urandom_range(1) ? 32'd0 : ipg - 1);
      end
      4: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(200000);
    endcase
  endfunction

  vec_t dir_tab[$];

  initial begin
    loc_t nil;
    int p;
    nil = '0;
    errors = 0;
    hold_off = 1'b0;
    quiet = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ibo_pkg::RegInodesPerGroup;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    inode_number_i = '0;
    out_stall_i = 1'b0;
    ipg_q = 17'd2048;
    bpg_q = 17'd8192;
    lbs_q = 3'd0;
    isz_q = 11'd128;
    itb_q = 32'd5;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows at reset config; typed rows are reserved inodes of group 0 and the first one after them
    dir_tab = '{
      '{32'd0,    1'b1, '{32'd5120, 32'd0, 1'b1}},
      '{32'd1,    1'b1, '{32'd5184, 32'd0, 1'b1}},
      '{32'd10,   1'b1, '{32'd5760, 32'd0, 1'b1}},
      '{32'd11,   1'b1, '{32'd6400, 32'd0, 1'b1}},
      '{32'd2047, 1'b0, nil},
      '{32'd2048, 1'b0, nil},
      '{32'd4096, 1'b0, nil},
      '{32'd6144, 1'b0, nil},
      '{32'd8192, 1'b0, nil},
      '{32'd10240, 1'b0, nil},
      '{32'd14336, 1'b0, nil},
      '{32'd18432, 1'b0, nil},
      '{32'hFFFF_FFFF, 1'b0, nil},
      '{32'h8000_0000, 1'b0, nil},
      '{32'h5555_5555, 1'b0, nil},
      '{32'hAAAA_AAAA, 1'b0, nil}
    };
    foreach (dir_tab[i]) send_item(dir_tab[i].num, 1'b0, dir_tab[i].want, dir_tab[i].typed);
    drain();

    // Zero inodes per group and the out-of-range block size shift
    cfg_all(32'd0, 32'h1FFFF, 32'd7, 32'h7FF, 32'hFFFF_FFFF);
    send_item(32'd0, 1'b0, nil, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, nil, 1'b0);
    send_item(32'd12345, 1'b0, nil, 1'b0);
    drain();

    // Random phases over several settings, extremes included
    for (p = 0; p < 6; p++) begin
      case (p)
        0: cfg_all(32'd1, 32'd1, 32'd0, 32'd128, 32'd0);
        1: cfg_all(32'd65536, 32'd65536, 32'd6, 32'd1024, 32'hFFFF_FFFF);
        2: cfg_all(32'd3, 32'd7, 32'd2, 32'd256, 32'd3);
        3: cfg_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        4: cfg_all($urandom_range(1, 65536), $urandom_range(1, 65536),
                   $urandom_range(6), $urandom_range(128, 1024), $urandom());
        default: cfg_all(32'd2048, 32'd8192, 32'd0, 32'd128, 32'd5);
      endcase
      quiet = (p == 2);
      if (p == 1) fork
        begin
          hold_off = 1'b1;
          repeat (150) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      repeat (NumRandom / 6) send_item(pick_num(), !quiet, nil, 1'b0);
      drain();
      quiet = 1'b0;
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
